// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property with an active-low reset that disables it.
`define RNIL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that holds during reset too.
`define RNIL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RNIL_ASSERT(lbl, clk, rst_n, prop, msg)
`define RNIL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/rnil_pkg.sv =====
package rnil_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 64;
  localparam int IDX_W       = 6;

  localparam logic [ID_W-1:0] EMPTY_ID = {ID_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_KEY   = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [IDX_W-1:0] entry_index;
    logic [ID_W-1:0] entry_id;
    logic [ID_W-1:0] key_chunk;
    logic            key_last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] nearest_id;
    logic            found;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRAP,
    ST_PICK
  } state_t;

endpackage

// ===== hw/rtl/ring_nearest_id_lookup.sv =====
// Nearest-identifier lookup on a hash ring, one table of 64-bit ids in a RAM with a registered read port.
// A write item or a non-final key chunk never raises busy, so the block stays ready for the next item.
// A final key chunk scans every slot, holding busy through the scan, the pipe drain, the wrap step and
// the pick step; the single RAM read port reads one slot a cycle.
// out_valid strobes when the result registered in the pick step appears; there is no stall input.
// Reset (sync, rst_n low): all slots read as empty (valid bits cleared), key accumulator zero.
`include "assert_macros.svh"

module ring_nearest_id_lookup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rnil_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output rnil_pkg::out_item_t  out_item
);

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  rnil_pkg::state_t state_r, state_nxt;

  logic accept;
  logic mem_we;
  logic lookup_go;       // final key chunk accepted: start the scan
  logic issue_en;        // RAM read issued this cycle
  logic issue_last;

  logic [rnil_pkg::CNT_W-1:0]  issue_cnt_r;
  logic [rnil_pkg::ADDR_W-1:0] rd_addr;
  logic [rnil_pkg::ADDR_W-1:0] wr_addr;

  // Table RAM: no reset; per-slot valid flops make unwritten slots read as empty.
  logic [rnil_pkg::ID_W-1:0]  mem [rnil_pkg::TABLE_DEPTH];
  logic [rnil_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [rnil_pkg::ID_W-1:0]  rd_data_r;
  logic                       rd_valid_r;

  // Key folding.
  logic [rnil_pkg::ID_W-1:0] acc_r;
  logic [rnil_pkg::ID_W-1:0] key_r;

  // Scan pipe: stage 1 = RAM data, stage 2 = distance, stage 3 = running best.
  logic                      s1_vld_r, s1_last_r;
  logic                      s2_vld_r, s2_last_r;
  logic [rnil_pkg::ID_W-1:0] s1_entry;
  logic [rnil_pkg::ID_W-1:0] s2_v_r;
  logic [rnil_pkg::ID_W-1:0] s2_d_r;
  logic                      s2_empty_r;

  logic [rnil_pkg::ID_W-1:0] best_r;
  logic [rnil_pkg::ID_W-1:0] best_dist_r;
  logic [rnil_pkg::ID_W-1:0] lo_r;
  logic [rnil_pkg::ID_W-1:0] hi_r;
  logic                      any_r;

  // Wrap step.
  logic                      above_r, below_r;
  logic [rnil_pkg::ID_W-1:0] wrap_r;
  logic [rnil_pkg::ID_W-1:0] wrap_a, wrap_b;
  logic                      take_far;

  logic                out_valid_r;
  rnil_pkg::out_item_t out_item_r;

  assign busy   = (state_r != rnil_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign mem_we = accept && (in_item.operation == rnil_pkg::OP_WRITE) &&
                  (32'(in_item.entry_index) < 32'(rnil_pkg::TABLE_DEPTH));
  assign wr_addr = rnil_pkg::ADDR_W'(in_item.entry_index);

  assign lookup_go = accept && (in_item.operation == rnil_pkg::OP_KEY) && in_item.key_last;

  assign issue_en   = (state_r == rnil_pkg::ST_SCAN) &&
                      (issue_cnt_r != rnil_pkg::CNT_W'(rnil_pkg::TABLE_DEPTH));
  assign issue_last = (issue_cnt_r == rnil_pkg::CNT_W'(rnil_pkg::TABLE_DEPTH - 1));
  assign rd_addr    = rnil_pkg::ADDR_W'(issue_cnt_r);

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rnil_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rnil_pkg::ST_IDLE: begin
        if (lookup_go) state_nxt = rnil_pkg::ST_SCAN;
      end
      rnil_pkg::ST_SCAN: begin
        // last slot has reached the running-best stage
        if (s2_vld_r && s2_last_r) state_nxt = rnil_pkg::ST_WRAP;
      end
      rnil_pkg::ST_WRAP: state_nxt = rnil_pkg::ST_PICK;
      rnil_pkg::ST_PICK: state_nxt = rnil_pkg::ST_IDLE;
      default:           state_nxt = rnil_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table RAM and valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_item.entry_id;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (mem_we) valid_r[wr_addr] <= 1'b1;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      issue_cnt_r <= '0;
      s1_vld_r    <= 1'b0;
      s1_last_r   <= 1'b0;
      s2_vld_r    <= 1'b0;
      s2_last_r   <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // XOR fold; cleared once the final chunk hands the key to the scan
      if (accept && (in_item.operation == rnil_pkg::OP_KEY)) begin
        acc_r <= in_item.key_last ? '0 : (acc_r ^ in_item.key_chunk);
      end

      if (state_r == rnil_pkg::ST_IDLE) begin
        issue_cnt_r <= '0;
      end else if (issue_en) begin
        issue_cnt_r <= issue_cnt_r + rnil_pkg::CNT_W'(1);
      end

      s1_vld_r  <= issue_en;
      s1_last_r <= issue_en && issue_last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;

      if (lookup_go) begin
        any_r <= 1'b0;
      end else if (s2_vld_r && !s2_empty_r) begin
        any_r <= 1'b1;
      end

      out_valid_r <= (state_r == rnil_pkg::ST_PICK);
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  assign s1_entry = rd_valid_r ? rd_data_r : rnil_pkg::EMPTY_ID;

  // ring top is all-ones minus one: top - x == ~x - 1
  assign wrap_a = (key_r > hi_r) ? ~key_r : key_r;
  assign wrap_b = (key_r > hi_r) ? lo_r   : ~hi_r;

  // far side wins only when strictly nearer
  assign take_far = (above_r || below_r) && (wrap_r < best_dist_r);

  always_ff @(posedge clk) begin
    if (lookup_go) begin
      key_r <= acc_r ^ in_item.key_chunk;
    end

    // stage 2: absolute distance
    s2_v_r     <= s1_entry;
    s2_empty_r <= (s1_entry == rnil_pkg::EMPTY_ID);
    s2_d_r     <= (s1_entry > key_r) ? (s1_entry - key_r) : (key_r - s1_entry);

    // stage 3: running best, min and max; lowest slot wins ties
    if (lookup_go) begin
      best_r      <= rnil_pkg::EMPTY_ID;
      best_dist_r <= rnil_pkg::EMPTY_ID;
      lo_r        <= rnil_pkg::EMPTY_ID;
      hi_r        <= '0;
    end else if (s2_vld_r && !s2_empty_r) begin
      if (s2_d_r < best_dist_r) begin
        best_r      <= s2_v_r;
        best_dist_r <= s2_d_r;
      end
      if (s2_v_r < lo_r) lo_r <= s2_v_r;
      if (s2_v_r > hi_r) hi_r <= s2_v_r;
    end

    if (state_r == rnil_pkg::ST_WRAP) begin
      above_r <= (key_r > hi_r);
      below_r <= (key_r < lo_r);
      wrap_r  <= wrap_a + wrap_b - rnil_pkg::ID_W'(1);
    end

    if (state_r == rnil_pkg::ST_PICK) begin
      if (!any_r) begin
        out_item_r.nearest_id <= rnil_pkg::EMPTY_ID;
        out_item_r.found      <= 1'b0;
      end else begin
        out_item_r.nearest_id <= take_far ? (above_r ? lo_r : hi_r) : best_r;
        out_item_r.found      <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RNIL_ASSERT(a_out_after_pick, clk, rst_n,
               out_valid_r |-> $past(state_r == rnil_pkg::ST_PICK),
               "result strobe without a pick step")
  `RNIL_ASSERT(a_cnt_bound, clk, rst_n,
               issue_cnt_r <= rnil_pkg::CNT_W'(rnil_pkg::TABLE_DEPTH),
               "scan counter past table depth")
  `RNIL_ASSERT(a_pipe_in_scan, clk, rst_n,
               s2_vld_r |-> (state_r == rnil_pkg::ST_SCAN),
               "scan pipe active outside scan")
  `RNIL_ASSERT(a_empty_result, clk, rst_n,
               (out_valid_r && !out_item_r.found) |->
                 (out_item_r.nearest_id == rnil_pkg::EMPTY_ID),
               "not-found result without sentinel")

endmodule
